// ===== src/fct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int TableEntries = 4096;
    localparam int SearchEnd    = 4084;
    localparam int AddrW        = $clog2(TableEntries);
    localparam int SearchLimit  = (SearchEnd < TableEntries) ? SearchEnd : TableEntries;
    localparam int SearchStart  = 2;
    localparam int EntryW       = 12;
    localparam int QueueDepth   = 2;
    localparam int QPtrW        = $clog2(QueueDepth);

    localparam logic [EntryW-1:0] ChainEnd    = 12'hFFF;
    localparam logic [EntryW-1:0] ChainEndMin = 12'hFF8;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_ALLOC = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_LINK
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [EntryW-1:0] cluster;
        logic [EntryW-1:0] value;
        logic              link;
        logic              in_range;
    } item_t;

endpackage

`default_nettype wire

// ===== src/fct_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fct_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic [fct_pkg::EntryW-1:0] cluster,
    input  wire logic [fct_pkg::EntryW-1:0] value,
    input  wire logic                       link_previous,
    input  wire logic                       hold,
    output logic                            q_valid,
    output fct_pkg::item_t                  q_item,
    input  wire logic                       q_pop
);

    fct_pkg::item_t                 q_reg [fct_pkg::QueueDepth];
    logic [fct_pkg::QPtrW-1:0]      wr_ptr_reg;
    logic [fct_pkg::QPtrW-1:0]      wr_ptr_next;
    logic [fct_pkg::QPtrW-1:0]      rd_ptr_reg;
    logic [fct_pkg::QPtrW-1:0]      rd_ptr_next;
    logic [fct_pkg::QPtrW:0]        count_reg;
    logic [fct_pkg::QPtrW:0]        count_next;
    logic                           push;
    logic                           pop;
    fct_pkg::item_t                 in_item;

    always_comb
    begin
        in_item.cmd      = fct_pkg::cmd_t'(cmd);
        in_item.cluster  = cluster;
        in_item.value    = value;
        in_item.link     = link_previous;
        in_item.in_range = ({1'b0, cluster} < (fct_pkg::EntryW + 1)'(fct_pkg::TableEntries));
    end

    assign in_stall = hold || (count_reg == (fct_pkg::QPtrW + 1)'(fct_pkg::QueueDepth));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fct_pkg::QPtrW'(fct_pkg::QueueDepth - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fct_pkg::QPtrW'(fct_pkg::QueueDepth - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/fct_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fct_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire fct_pkg::item_t             q_item,
    output logic                            q_pop,
    output logic                            clearing,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [fct_pkg::EntryW-1:0]      result_cluster,
    output logic [fct_pkg::EntryW-1:0]      entry_value,
    output logic                            end_of_chain,
    output logic                            entry_free,
    output logic                            found
);

    logic [fct_pkg::EntryW-1:0]     mem [fct_pkg::TableEntries];
    logic                           mem_we;
    logic [fct_pkg::AddrW-1:0]      mem_waddr;
    logic [fct_pkg::EntryW-1:0]     mem_wdata;
    logic                           mem_re;
    logic [fct_pkg::AddrW-1:0]      mem_raddr;
    logic [fct_pkg::EntryW-1:0]     rdata_reg;

    fct_pkg::state_t                state_reg;
    fct_pkg::state_t                state_next;
    logic [fct_pkg::AddrW-1:0]      clr_reg;
    logic [fct_pkg::AddrW-1:0]      clr_next;
    logic [fct_pkg::AddrW-1:0]      chk_reg;
    logic [fct_pkg::AddrW-1:0]      chk_next;
    fct_pkg::item_t                 cur_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [fct_pkg::EntryW-1:0]     res_cl_reg;
    logic [fct_pkg::EntryW-1:0]     res_cl_next;
    logic [fct_pkg::EntryW-1:0]     ent_reg;
    logic [fct_pkg::EntryW-1:0]     ent_next;
    logic                           eoc_reg;
    logic                           eoc_next;
    logic                           fre_reg;
    logic                           fre_next;
    logic                           fnd_reg;
    logic                           fnd_next;
    logic                           load_out;

    logic                           slot_free;
    logic                           take;
    logic                           scan_hit;
    logic                           scan_last;
    logic [fct_pkg::AddrW:0]        chk_inc;
    logic                           do_link;
    logic                           clr_last;

    assign slot_free = !out_valid_reg || !out_stall;
    assign take      = (state_reg == fct_pkg::ST_IDLE) && q_valid && slot_free;
    assign q_pop     = take;
    assign clearing  = (state_reg == fct_pkg::ST_CLEAR);
    assign chk_inc   = {1'b0, chk_reg} + 1'b1;
    assign scan_hit  = (rdata_reg == '0);
    assign scan_last = (chk_inc >= (fct_pkg::AddrW + 1)'(fct_pkg::SearchLimit));
    assign do_link   = (cur_reg.cmd == fct_pkg::CMD_ALLOC) && cur_reg.link && cur_reg.in_range
                       && (cur_reg.cluster != fct_pkg::EntryW'(chk_reg));
    assign clr_last  = (clr_reg == fct_pkg::AddrW'(fct_pkg::TableEntries - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fct_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = fct_pkg::ST_IDLE;
                end
            end
            fct_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (q_item.cmd)
                        fct_pkg::CMD_READ:
                            state_next = q_item.in_range ? fct_pkg::ST_READ : fct_pkg::ST_IDLE;
                        fct_pkg::CMD_WRITE:
                            state_next = fct_pkg::ST_IDLE;
                        default:
                            state_next = fct_pkg::ST_SCAN;
                    endcase
                end
            end
            fct_pkg::ST_READ:
            begin
                state_next = fct_pkg::ST_IDLE;
            end
            fct_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = do_link ? fct_pkg::ST_LINK : fct_pkg::ST_IDLE;
                end
                else if (scan_last)
                begin
                    state_next = fct_pkg::ST_IDLE;
                end
            end
            fct_pkg::ST_LINK:
            begin
                state_next = fct_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fct_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        clr_next    = clr_reg;
        chk_next    = chk_reg;
        load_out    = 1'b0;
        res_cl_next = '0;
        ent_next    = '0;
        eoc_next    = 1'b0;
        fre_next    = 1'b0;
        fnd_next    = 1'b0;
        case (state_reg)
            fct_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            fct_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (q_item.cmd)
                        fct_pkg::CMD_READ:
                        begin
                            if (q_item.in_range)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = q_item.cluster[fct_pkg::AddrW-1:0];
                            end
                            else
                            begin
                                load_out = 1'b1;
                                fre_next = 1'b1;
                            end
                        end
                        fct_pkg::CMD_WRITE:
                        begin
                            mem_we    = q_item.in_range;
                            mem_waddr = q_item.cluster[fct_pkg::AddrW-1:0];
                            mem_wdata = q_item.value;
                            load_out  = 1'b1;
                        end
                        default:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = fct_pkg::AddrW'(fct_pkg::SearchStart);
                            chk_next  = fct_pkg::AddrW'(fct_pkg::SearchStart);
                        end
                    endcase
                end
            end
            fct_pkg::ST_READ:
            begin
                load_out = 1'b1;
                ent_next = rdata_reg;
                eoc_next = (rdata_reg >= fct_pkg::ChainEndMin);
                fre_next = (rdata_reg == '0);
            end
            fct_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    load_out    = 1'b1;
                    res_cl_next = fct_pkg::EntryW'(chk_reg);
                    fnd_next    = 1'b1;
                    mem_we      = (cur_reg.cmd == fct_pkg::CMD_ALLOC);
                    mem_waddr   = chk_reg;
                    mem_wdata   = fct_pkg::ChainEnd;
                end
                else if (scan_last)
                begin
                    load_out = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = chk_inc[fct_pkg::AddrW-1:0];
                    chk_next  = chk_inc[fct_pkg::AddrW-1:0];
                end
            end
            fct_pkg::ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg.cluster[fct_pkg::AddrW-1:0];
                mem_wdata = fct_pkg::EntryW'(chk_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fct_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg <= chk_next;
        if (take)
        begin
            cur_reg <= q_item;
        end
        if (load_out)
        begin
            res_cl_reg <= res_cl_next;
            ent_reg    <= ent_next;
            eoc_reg    <= eoc_next;
            fre_reg    <= fre_next;
            fnd_reg    <= fnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_cluster = res_cl_reg;
    assign entry_value    = ent_reg;
    assign end_of_chain   = eoc_reg;
    assign entry_free     = fre_reg;
    assign found          = fnd_reg;

endmodule

`default_nettype wire

// ===== src/fat12_cluster_table_engine.sv =====
// FAT12 cluster table with read, write, find-free and allocate-and-link commands.
// After reset the table is cleared one entry per cycle; in_stall stays
// high for that time. Commands pass through a two-entry queue into an executor that owns
// the single-port table memory with registered read data, so every command runs alone:
// a write completes when taken, a read fetches the entry, then returns it; find-free and
// allocate walk entries from cluster 2 (up to 4082), plus a link step when allocate links
// the previous cluster. One result is held in an output register per command.
`timescale 1ns / 1ps
`default_nettype none

module fat12_cluster_table_engine
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic [fct_pkg::EntryW-1:0] cluster,
    input  wire logic [fct_pkg::EntryW-1:0] value,
    input  wire logic                       link_previous,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [fct_pkg::EntryW-1:0]      result_cluster,
    output logic [fct_pkg::EntryW-1:0]      entry_value,
    output logic                            end_of_chain,
    output logic                            entry_free,
    output logic                            found
);

    logic           q_valid;
    fct_pkg::item_t q_item;
    logic           q_pop;
    logic           clearing;

    fct_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .cluster       (cluster),
        .value         (value),
        .link_previous (link_previous),
        .hold          (clearing),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    fct_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_cluster (result_cluster),
        .entry_value    (entry_value),
        .end_of_chain   (end_of_chain),
        .entry_free     (entry_free),
        .found          (found)
    );

endmodule

`default_nettype wire
